FILE: rtl/infix_to_postfix_converter_unit_defines.svh
// Assertion macros for the infix to postfix converter RTL.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define IPC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ipc_pkg.sv
// Shared types, constants and lookup functions of the infix to postfix converter.
// No dependencies; every RTL module of the converter imports this package.
`default_nettype none

package ipc_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int OP_W        = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_NUL     = 8'h00;

    localparam logic [OP_W-1:0] OP_LPAREN  = 4'd0;
    localparam logic [OP_W-1:0] OP_OR      = 4'd1;
    localparam logic [OP_W-1:0] OP_XOR     = 4'd2;
    localparam logic [OP_W-1:0] OP_AND     = 4'd3;
    localparam logic [OP_W-1:0] OP_ADD     = 4'd4;
    localparam logic [OP_W-1:0] OP_SUB     = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd6;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd7;
    localparam logic [OP_W-1:0] OP_MOD     = 4'd8;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    typedef enum logic [1:0] {
        CMD_EMIT  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_FLUSH = 2'd3
    } t_cmd_kind;

    // One classified token handed from the front end to the back end.
    typedef struct packed {
        t_cmd_kind       kind;
        logic [7:0]      ch;
        logic [OP_W-1:0] code;
        logic            lead_space;
    } t_cmd;

    typedef struct packed {
        logic            hit;
        logic [OP_W-1:0] code;
    } t_op_lookup;

    function automatic t_op_lookup f_op_lookup(input logic [7:0] ch);
        t_op_lookup r;
        r.hit  = 1'b1;
        r.code = OP_LPAREN;
        case (ch)
            CH_LPAREN:  r.code = OP_LPAREN;
            CH_PIPE:    r.code = OP_OR;
            CH_CARET:   r.code = OP_XOR;
            CH_AMP:     r.code = OP_AND;
            CH_PLUS:    r.code = OP_ADD;
            CH_MINUS:   r.code = OP_SUB;
            CH_STAR:    r.code = OP_MUL;
            CH_SLASH:   r.code = OP_DIV;
            CH_PERCENT: r.code = OP_MOD;
            default:    r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    // Precedence shifted up by one so that the open parenthesis ranks lowest at zero.
    function automatic logic [2:0] f_op_rank(input logic [OP_W-1:0] code);
        logic [2:0] r;
        case (code)
            OP_OR:                   r = 3'd1;
            OP_XOR:                  r = 3'd2;
            OP_AND:                  r = 3'd3;
            OP_ADD, OP_SUB:          r = 3'd4;
            OP_MUL, OP_DIV, OP_MOD:  r = 3'd5;
            default:                 r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_op_char(input logic [OP_W-1:0] code);
        logic [7:0] r;
        case (code)
            OP_LPAREN: r = CH_LPAREN;
            OP_OR:     r = CH_PIPE;
            OP_XOR:    r = CH_CARET;
            OP_AND:    r = CH_AMP;
            OP_ADD:    r = CH_PLUS;
            OP_SUB:    r = CH_MINUS;
            OP_MUL:    r = CH_STAR;
            OP_DIV:    r = CH_SLASH;
            OP_MOD:    r = CH_PERCENT;
            default:   r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/infix_to_postfix_converter_unit.sv
// An operand byte passes through the command queue and the output register; an operator
// popped by a command passes through the queue, the pop state and the output register.
// Throughput: one operand byte, or one push or close popping nothing, per cycle unless the
// output stalls; each popped operator is followed by a blank and a line end by a newline.
// A four-entry command queue lets input transfers continue while operators are popped.
// Reset is synchronous, active low, and empties the stack, the queue and the status.
`default_nettype none

module infix_to_postfix_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_ch,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char,
    output logic       o_last,
    output logic [1:0] o_error
);
    import ipc_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_head;

    ipc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_ch       (i_ch),
        .i_line_end (i_line_end),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    ipc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    ipc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

`default_nettype wire

FILE: rtl/ipc_front.sv
// Front end: takes input transfers, tracks operand mode and classifies each byte.
// Depends on ipc_pkg; feeds ipc_queue.
`default_nettype none

module ipc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_ch,
    input  logic          i_line_end,
    input  logic          i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output ipc_pkg::t_cmd o_cmd
);
    import ipc_pkg::*;

    logic       r_in_operand;
    logic       n_in_operand;
    logic       accept;
    t_op_lookup lk;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign lk         = f_op_lookup(i_ch);

    always_comb begin
        n_in_operand     = r_in_operand;
        o_push           = 1'b0;
        o_cmd.kind       = CMD_EMIT;
        o_cmd.ch         = i_ch;
        o_cmd.code       = lk.code;
        o_cmd.lead_space = r_in_operand;
        if (accept) begin
            if (i_line_end) begin
                o_cmd.kind   = CMD_FLUSH;
                o_push       = 1'b1;
                n_in_operand = 1'b0;
            end else if (r_in_operand) begin
                // Inside an operand every byte is copied; a blank closes it.
                o_push = 1'b1;
                if (i_ch == CH_SPACE) begin
                    n_in_operand = 1'b0;
                end
            end else if (i_ch == CH_SPACE) begin
                o_push = 1'b0;
            end else if (i_ch == CH_RPAREN) begin
                o_cmd.kind = CMD_CLOSE;
                o_push     = 1'b1;
            end else if (lk.hit) begin
                o_cmd.kind = CMD_PUSH;
                o_push     = 1'b1;
            end else begin
                o_push       = 1'b1;
                n_in_operand = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_operand <= 1'b0;
        end else begin
            r_in_operand <= n_in_operand;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ipc_queue.sv
// Short command queue between the front end and the back end.
// Depends on ipc_pkg for the command type and the depth.
`default_nettype none

module ipc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ipc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output ipc_pkg::t_cmd o_head
);
    import ipc_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0]  r_wr_ptr;
    logic [Q_IDX_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;
    logic [Q_CNT_W-1:0]  n_count;

    assign o_full  = r_count == Q_CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_IDX_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_IDX_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ipc_back.sv
// Back end: operator stack, pop sequencer and output register.
// Depends on ipc_pkg and the assertion macros header; drains ipc_queue.
`default_nettype none

`include "infix_to_postfix_converter_unit_defines.svh"

module ipc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  ipc_pkg::t_cmd i_q_head,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_char,
    output logic          o_last,
    output logic [1:0]    o_error
);
    import ipc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_OP   = 4'b0010,
        ST_SP   = 4'b0100,
        ST_NL   = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [OP_W-1:0]   r_stack [STACK_DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        r_err;
    logic [1:0]        n_err;
    logic [OP_W-1:0]   r_pop_code;
    logic [OP_W-1:0]   n_pop_code;

    logic              r_out_valid;
    logic [7:0]        r_out_char;
    logic              r_out_last;
    logic [1:0]        r_out_err;

    logic              can_emit;
    logic              emit;
    logic              emit_last;
    logic [7:0]        emit_char;
    logic              do_pop;
    logic              do_finish;
    logic              stack_we;
    logic [IDX_W-1:0]  top_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [OP_W-1:0]   top_code;
    logic              have_top;
    logic              stack_full;
    logic              more;
    logic              nl_done;
    logic              state_clear;
    logic              err_hold;

    assign top_idx    = IDX_W'(r_count - CNT_W'(1));
    assign wr_idx     = IDX_W'(r_count);
    assign top_code   = r_stack[top_idx];
    assign have_top   = r_count != '0;
    assign stack_full = r_count >= CNT_W'(STACK_DEPTH);
    assign can_emit   = !r_out_valid || !i_out_stall;

    // Whether the current command pops another entry off the stack.
    always_comb begin
        case (i_q_head.kind)
            CMD_PUSH:  more = have_top && (i_q_head.code != OP_LPAREN) &&
                              (f_op_rank(top_code) >= f_op_rank(i_q_head.code));
            CMD_CLOSE: more = have_top && (top_code != OP_LPAREN);
            CMD_FLUSH: more = have_top;
            default:   more = 1'b0;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_err      = r_err;
        n_pop_code = r_pop_code;
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_char  = CH_SPACE;
        do_pop     = 1'b0;
        do_finish  = 1'b0;
        stack_we   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_head.kind)
                        CMD_EMIT: begin
                            if (can_emit) begin
                                emit      = 1'b1;
                                emit_char = i_q_head.ch;
                                emit_last = 1'b1;
                                o_q_pop   = 1'b1;
                            end
                        end
                        CMD_FLUSH: begin
                            // An open operand is closed with a blank before the flush.
                            if (!i_q_head.lead_space || can_emit) begin
                                emit = i_q_head.lead_space;
                                if (more) begin
                                    do_pop = 1'b1;
                                end else begin
                                    n_state = ST_NL;
                                end
                            end
                        end
                        default: begin
                            if (more) begin
                                do_pop = 1'b1;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_OP: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_char = f_op_char(r_pop_code);
                    n_state   = ST_SP;
                end
            end
            ST_SP: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_last = (i_q_head.kind != CMD_FLUSH) && !more;
                    if (more) begin
                        do_pop = 1'b1;
                    end else if (i_q_head.kind == CMD_FLUSH) begin
                        n_state = ST_NL;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
            end
            ST_NL: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_char = CH_NEWLINE;
                    emit_last = 1'b1;
                    n_err     = ERR_NONE;
                    o_q_pop   = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_pop) begin
            n_pop_code = top_code;
            n_count    = r_count - CNT_W'(1);
            n_state    = ST_OP;
        end

        // End of a push or a close: store the operator or drop the matching parenthesis, else flag an error.
        if (do_finish) begin
            o_q_pop = 1'b1;
            n_state = ST_IDLE;
            if (i_q_head.kind == CMD_PUSH) begin
                if (stack_full) begin
                    if (r_err == ERR_NONE) begin
                        n_err = ERR_OVERFLOW;
                    end
                end else begin
                    stack_we = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
            end else if (have_top) begin
                n_count = r_count - CNT_W'(1);
            end else if (r_err == ERR_NONE) begin
                n_err = ERR_UNMATCHED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[wr_idx] <= i_q_head.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_code <= n_pop_code;
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

    assign nl_done     = (r_state == ST_NL) && can_emit;
    assign state_clear = (r_err == ERR_NONE) && (r_count == '0);
    assign err_hold    = (r_err != ERR_NONE) && (r_state != ST_NL);

    `IPC_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
    `IPC_ASSERT_NEXT(a_flush_clears, nl_done, state_clear, "line end left state behind")
    `IPC_ASSERT_NEXT(a_err_sticky, err_hold, $stable(r_err), "error status changed early")

endmodule

`default_nettype wire
